// ----- src/midi_voice_allocator_assert.svh -----
// Assertion macros shared by the checker of the MIDI voice allocator.
`ifndef MIDI_VOICE_ALLOCATOR_ASSERT_SVH
`define MIDI_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MVA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define MVA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mva_pkg.sv -----
// Types, codes and constants shared by the MIDI voice allocator files.
package mva_pkg;

	// Voice count limit and register reset value.
	localparam int DEF_MAX_VOICES = 8;
	localparam logic [3:0] POLY_RESET = 4'd8;

	// Key map layout: 128 keys as 16 rows of 8 bits.
	localparam int KEY_ROWS = 16;
	localparam int ROW_AW   = 4;
	localparam int ROW_BITS = 8;

	// Status nibbles that the block handles.
	localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
	localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
	localparam logic [3:0] STAT_CTRL     = 4'hB;
	localparam logic [3:0] STAT_BEND     = 4'hE;

	// Controller numbers.
	localparam logic [6:0] CC_MOD           = 7'h01;
	localparam logic [6:0] CC_DATA_ENTRY    = 7'h06;
	localparam logic [6:0] CC_RPN_LSB       = 7'h64;
	localparam logic [6:0] CC_RPN_MSB       = 7'h65;
	localparam logic [6:0] CC_ALL_NOTES_OFF = 7'h7B;

	// Bend wheel centre and reset range.
	localparam logic signed [14:0] BEND_CENTRE = 15'sd8192;
	localparam logic [6:0] RANGE_RESET = 7'd4;

	typedef enum logic [2:0] {
		ACT_NONE        = 3'd0,
		ACT_START       = 3'd1,
		ACT_LEGATO      = 3'd2,
		ACT_RELEASE     = 3'd3,
		ACT_RELEASE_ALL = 3'd4,
		ACT_CONTROLLER  = 3'd5,
		ACT_NO_VOICE    = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		MSG_NONE,
		MSG_NOTE_ON,
		MSG_NOTE_OFF,
		MSG_CTRL,
		MSG_BEND
	} msg_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_EXEC,
		FSM_LEGATO,
		FSM_PUSH
	} fsm_t;

	// Input word, last field in the lowest bits.
	typedef struct packed {
		logic [3:0] pad;
		logic [3:0] byte_count;
		logic [7:0] data_second;
		logic [7:0] data_first;
		logic [7:0] status_byte;
	} in_word_t;

	// Result word, last field in the lowest bits.
	typedef struct packed {
		logic [1:0]         pad;
		logic [6:0]         modulation;
		logic [6:0]         bend_range_out;
		logic signed [14:0] bend_fixed;
		logic [7:0]         released_mask;
		logic [6:0]         velocity;
		logic [6:0]         note_number;
		logic [2:0]         voice;
	} out_word_t;

	// Key map access request.
	typedef struct packed {
		logic                rd_en;
		logic [ROW_AW-1:0]   rd_row;
		logic                wr_en;
		logic [ROW_AW-1:0]   wr_row;
		logic [ROW_BITS-1:0] wr_data;
		logic                clr;
	} km_req_t;

	// Key map response.
	typedef struct packed {
		logic [ROW_BITS-1:0] rd_data;
		logic [KEY_ROWS-1:0] row_any;
	} km_rsp_t;

endpackage

// ----- src/midi_voice_allocator.sv -----
// The key row of an accepted word is read in idle and written back in the execute state, whose
// result goes to a pending register; a mono note-off moving legato to another key adds a legato
// state using the second read of the highest held row. The push state waits until the output
// register is free, loads it and returns to idle for the next word; the word is held until taken.
// Reset is asynchronous: keys are cleared through the row flags at once, voices are freed,
// controllers take their defaults and polyphony returns to 8; no clearing pass follows.
module midi_voice_allocator #(
	parameter int MAX_VOICES = mva_pkg::DEF_MAX_VOICES
) (
	input  logic        clk,
	input  logic        arst_n,
	// Polyphony register write.
	input  logic        polyphony_wr_en,
	input  logic [3:0]  polyphony_wr_data,
	// Message words in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // status_byte, data_first, data_second, byte_count
	// Result words out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // voice, note_number, velocity, released_mask,
	                              // bend_fixed, bend_range_out, modulation
	output logic [2:0]  m_tuser   // action
);

	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

	mva_pkg::fsm_t   state_q, state_d;
	mva_pkg::in_word_t in_w;
	mva_pkg::km_req_t km_req;
	mva_pkg::km_rsp_t km_rsp;

	// Decoded message.
	logic [3:0]      dec_nib;
	logic [6:0]      dec_d1, dec_d2;
	mva_pkg::msg_t   dec_kind;
	mva_pkg::msg_t   kind_q;
	logic [6:0]      d1_q, d2_q;

	// Register and controller state.
	logic [3:0]         polyphony_q;
	logic [4:0]         poly_eff;
	logic               mono;
	logic [6:0]         rpn_lsb_q, rpn_msb_q, range_q, mod_q;
	logic signed [14:0] bend_q;
	logic signed [14:0] wheel_off;
	logic signed [22:0] bend_prod;

	// Voice table.
	logic [6:0]            vnote_q [MAX_VOICES];
	logic [6:0]            vvel_q  [MAX_VOICES];
	logic [MAX_VOICES-1:0] vfree_q;
	logic [MAX_VOICES-1:0] busy, hit_all, hit_act, free_act;
	logic                  hit_found, free_found, sel_ok;
	logic [VW-1:0]         hit_idx, free_idx, sel_idx;
	logic [3:0]            sel_w;
	logic [15:0]           mask_w;

	// Key row handling.
	logic [7:0]                   row_new;
	logic [mva_pkg::KEY_ROWS-1:0] any_new;
	logic                         any_held;
	logic [mva_pkg::ROW_AW-1:0]   hi_row;
	logic [mva_pkg::ROW_AW-1:0]   hi_row_q;
	logic                         fwd_q;
	logic [7:0]                   fwd_row_q;
	logic [7:0]                   row_l;
	logic [2:0]                   hi_bit;
	logic [6:0]                   leg_key;

	// Effects and results.
	logic do_on, do_off, do_all, do_leg, legato_go, push;
	mva_pkg::action_t exec_act, res_act_q, out_act_q;
	logic [2:0] exec_voice, res_voice_q;
	logic [6:0] exec_note, exec_vel, res_note_q, res_vel_q;
	logic [7:0] exec_mask, res_mask_q;
	mva_pkg::out_word_t out_word_q;
	logic m_tvalid_q;

	assign in_w = s_tdata;

	// Message decode: absent bytes read as zero, long messages are ignored.
	always_comb begin
		dec_nib = (in_w.byte_count >= 4'd1 && in_w.byte_count <= 4'd4) ?
			in_w.status_byte[7:4] : 4'h0;
		dec_d1  = (in_w.byte_count >= 4'd2) ? in_w.data_first[6:0] : 7'd0;
		dec_d2  = (in_w.byte_count >= 4'd3) ? in_w.data_second[6:0] : 7'd0;
		priority if (dec_nib == mva_pkg::STAT_NOTE_ON && dec_d2 != 7'd0) begin
			dec_kind = mva_pkg::MSG_NOTE_ON;
		end else if (dec_nib == mva_pkg::STAT_NOTE_ON || dec_nib == mva_pkg::STAT_NOTE_OFF) begin
			dec_kind = mva_pkg::MSG_NOTE_OFF;
		end else if (dec_nib == mva_pkg::STAT_CTRL) begin
			dec_kind = mva_pkg::MSG_CTRL;
		end else if (dec_nib == mva_pkg::STAT_BEND) begin
			dec_kind = mva_pkg::MSG_BEND;
		end else begin
			dec_kind = mva_pkg::MSG_NONE;
		end
	end

	// Accepted message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= mva_pkg::MSG_NONE;
		end else if (s_tvalid && s_tready) begin
			kind_q <= dec_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			d1_q <= dec_d1;
			d2_q <= dec_d2;
		end
	end

	// Effective polyphony: zero acts as mono, values above the voice count are clipped.
	always_comb begin
		if (polyphony_q == 4'd0) begin
			poly_eff = 5'd1;
		end else if ({1'b0, polyphony_q} > 5'(MAX_VOICES)) begin
			poly_eff = 5'(MAX_VOICES);
		end else begin
			poly_eff = {1'b0, polyphony_q};
		end
	end
	assign mono = (poly_eff == 5'd1);

	// Voice search: voice 0 in mono mode, else reuse the voice holding the note, else the first free one.
	always_comb begin
		hit_found = 1'b0;
		free_found = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int v = 0; v < MAX_VOICES; v++) begin
			busy[v]     = !vfree_q[v];
			hit_all[v]  = busy[v] && (vnote_q[v] == d1_q);
			hit_act[v]  = hit_all[v] && (5'(v) < poly_eff);
			free_act[v] = vfree_q[v] && (5'(v) < poly_eff);
		end
		for (int v = MAX_VOICES - 1; v >= 0; v--) begin
			if (hit_act[v]) begin
				hit_found = 1'b1;
				hit_idx = VW'(v);
			end
			if (free_act[v]) begin
				free_found = 1'b1;
				free_idx = VW'(v);
			end
		end
		priority if (mono) begin
			sel_ok = 1'b1;
			sel_idx = '0;
		end else if (hit_found) begin
			sel_ok = 1'b1;
			sel_idx = hit_idx;
		end else if (free_found) begin
			sel_ok = 1'b1;
			sel_idx = free_idx;
		end else begin
			sel_ok = 1'b0;
			sel_idx = '0;
		end
	end

	// Key row update and the highest row still holding a key.
	always_comb begin
		row_new = km_rsp.rd_data;
		row_new[d1_q[2:0]] = (kind_q == mva_pkg::MSG_NOTE_ON);
		any_new = km_rsp.row_any;
		any_new[d1_q[6:3]] = |row_new;
		any_held = |any_new;
		hi_row = '0;
		for (int r = 0; r < mva_pkg::KEY_ROWS; r++) begin
			if (any_new[r]) begin
				hi_row = mva_pkg::ROW_AW'(r);
			end
		end
	end

	// Highest key within the chosen row.
	always_comb begin
		row_l = fwd_q ? fwd_row_q : km_rsp.rd_data;
		hi_bit = '0;
		for (int b = 0; b < mva_pkg::ROW_BITS; b++) begin
			if (row_l[b]) begin
				hi_bit = 3'(b);
			end
		end
		leg_key = {hi_row_q, hi_bit};
	end

	assign do_on  = (state_q == mva_pkg::FSM_EXEC) && (kind_q == mva_pkg::MSG_NOTE_ON) && sel_ok;
	assign do_off = (state_q == mva_pkg::FSM_EXEC) && (kind_q == mva_pkg::MSG_NOTE_OFF);
	assign do_all = (state_q == mva_pkg::FSM_EXEC) && (kind_q == mva_pkg::MSG_CTRL) &&
		(d1_q == mva_pkg::CC_ALL_NOTES_OFF);
	assign do_leg = (state_q == mva_pkg::FSM_LEGATO);
	assign legato_go = mono && (kind_q == mva_pkg::MSG_NOTE_OFF) && any_held;
	assign push = (state_q == mva_pkg::FSM_PUSH) && (!m_tvalid_q || m_tready);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mva_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and key map requests.
	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		km_req = '0;
		unique case (state_q)
			mva_pkg::FSM_IDLE: begin
				s_tready = 1'b1;
				km_req.rd_en = s_tvalid;
				km_req.rd_row = dec_d1[6:3];
				if (s_tvalid) begin
					state_d = mva_pkg::FSM_EXEC;
				end
			end
			mva_pkg::FSM_EXEC: begin
				km_req.wr_en = (kind_q == mva_pkg::MSG_NOTE_ON) ||
					(kind_q == mva_pkg::MSG_NOTE_OFF);
				km_req.wr_row = d1_q[6:3];
				km_req.wr_data = row_new;
				km_req.clr = do_all;
				km_req.rd_en = legato_go && (hi_row != d1_q[6:3]);
				km_req.rd_row = hi_row;
				state_d = legato_go ? mva_pkg::FSM_LEGATO : mva_pkg::FSM_PUSH;
			end
			mva_pkg::FSM_LEGATO: begin
				state_d = mva_pkg::FSM_PUSH;
			end
			mva_pkg::FSM_PUSH: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = mva_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = mva_pkg::FSM_IDLE;
			end
		endcase
	end

	mva_keymap u_keymap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (km_req),
		.rsp    (km_rsp)
	);

	// The legato row is forwarded when it is the row written in the same cycle.
	always_ff @(posedge clk) begin
		if (state_q == mva_pkg::FSM_EXEC) begin
			hi_row_q  <= hi_row;
			fwd_q     <= (hi_row == d1_q[6:3]);
			fwd_row_q <= row_new;
		end
	end

	// Voice free flags and velocities.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vfree_q <= '1;
			for (int v = 0; v < MAX_VOICES; v++) begin
				vvel_q[v] <= 7'd0;
			end
		end else begin
			for (int v = 0; v < MAX_VOICES; v++) begin
				if (do_all || (do_off && hit_all[v])) begin
					vfree_q[v] <= 1'b1;
				end else if (do_on && sel_idx == VW'(v)) begin
					vfree_q[v] <= 1'b0;
				end else if (do_leg && v == 0) begin
					vfree_q[v] <= 1'b0;
				end
				if (do_on && sel_idx == VW'(v)) begin
					vvel_q[v] <= d2_q;
				end
			end
		end
	end

	// Voice notes; only meaningful while the voice is busy.
	always_ff @(posedge clk) begin
		for (int v = 0; v < MAX_VOICES; v++) begin
			if (do_on && sel_idx == VW'(v)) begin
				vnote_q[v] <= d1_q;
			end else if (do_leg && v == 0) begin
				vnote_q[v] <= leg_key;
			end
		end
	end

	// Pitch bend: offset wheel times range, floored division by 64.
	assign wheel_off = $signed({1'b0, d2_q, d1_q}) - mva_pkg::BEND_CENTRE;
	assign bend_prod = wheel_off * $signed({1'b0, range_q});

	// Polyphony register and controllers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polyphony_q <= mva_pkg::POLY_RESET;
			rpn_lsb_q   <= 7'd0;
			rpn_msb_q   <= 7'd0;
			range_q     <= mva_pkg::RANGE_RESET;
			mod_q       <= 7'd0;
			bend_q      <= '0;
		end else begin
			if (polyphony_wr_en) begin
				polyphony_q <= polyphony_wr_data;
			end
			if (state_q == mva_pkg::FSM_EXEC && kind_q == mva_pkg::MSG_CTRL) begin
				unique case (d1_q)
					mva_pkg::CC_RPN_LSB: rpn_lsb_q <= d2_q;
					mva_pkg::CC_RPN_MSB: rpn_msb_q <= d2_q;
					mva_pkg::CC_MOD:     mod_q <= d2_q;
					mva_pkg::CC_DATA_ENTRY: begin
						if (rpn_lsb_q == 7'd0 && rpn_msb_q == 7'd0) begin
							range_q <= d2_q;
						end
					end
					default: begin
					end
				endcase
			end
			if (state_q == mva_pkg::FSM_EXEC && kind_q == mva_pkg::MSG_BEND) begin
				bend_q <= bend_prod[20:6];
			end
		end
	end

	assign sel_w = 4'(sel_idx);

	// Result of the execute cycle.
	always_comb begin
		exec_act = mva_pkg::ACT_NONE;
		exec_voice = 3'd0;
		exec_note = 7'd0;
		exec_vel = 7'd0;
		mask_w = '0;
		unique case (kind_q)
			mva_pkg::MSG_NOTE_ON: begin
				if (sel_ok) begin
					exec_act = mva_pkg::ACT_START;
					exec_voice = sel_w[2:0];
					exec_note = d1_q;
					exec_vel = d2_q;
				end else begin
					exec_act = mva_pkg::ACT_NO_VOICE;
				end
			end
			mva_pkg::MSG_NOTE_OFF: begin
				exec_act = mva_pkg::ACT_RELEASE;
				mask_w = 16'(hit_all);
			end
			mva_pkg::MSG_CTRL: begin
				if (d1_q == mva_pkg::CC_ALL_NOTES_OFF) begin
					exec_act = mva_pkg::ACT_RELEASE_ALL;
					mask_w = 16'(busy);
				end else begin
					exec_act = mva_pkg::ACT_CONTROLLER;
				end
			end
			mva_pkg::MSG_BEND: begin
				exec_act = mva_pkg::ACT_CONTROLLER;
			end
			mva_pkg::MSG_NONE: begin
			end
			default: begin
			end
		endcase
		exec_mask = mask_w[7:0];
	end

	// Pending result; a legato move overrides the voice fields and keeps the mask.
	always_ff @(posedge clk) begin
		if (state_q == mva_pkg::FSM_EXEC) begin
			res_act_q   <= exec_act;
			res_voice_q <= exec_voice;
			res_note_q  <= exec_note;
			res_vel_q   <= exec_vel;
			res_mask_q  <= exec_mask;
		end else if (do_leg) begin
			res_act_q   <= mva_pkg::ACT_LEGATO;
			res_voice_q <= 3'd0;
			res_note_q  <= leg_key;
			res_vel_q   <= vvel_q[0];
		end
	end

	// Output register: holds a word until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_act_q                 <= res_act_q;
			out_word_q.pad            <= '0;
			out_word_q.voice          <= res_voice_q;
			out_word_q.note_number    <= res_note_q;
			out_word_q.velocity       <= res_vel_q;
			out_word_q.released_mask  <= res_mask_q;
			out_word_q.bend_fixed     <= bend_q;
			out_word_q.bend_range_out <= range_q;
			out_word_q.modulation     <= mod_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_word_q;
	assign m_tuser  = out_act_q;

endmodule

// ----- src/mva_keymap.sv -----
// Held-key map: a 16 x 8 synchronous memory with a per-row occupancy flag.
module mva_keymap (
	input  logic              clk,
	input  logic              arst_n,
	input  mva_pkg::km_req_t  req,
	output mva_pkg::km_rsp_t  rsp
);

	logic [mva_pkg::ROW_BITS-1:0] mem [mva_pkg::KEY_ROWS];
	logic [mva_pkg::ROW_BITS-1:0] rd_data_q;
	logic                         rd_any_q;
	logic [mva_pkg::KEY_ROWS-1:0] row_any_q;

	// Memory array: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_row] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_row];
		end
	end

	// A row whose flag is clear reads as empty, so reset and all-notes-off need no sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_any_q <= '0;
			rd_any_q  <= 1'b0;
		end else begin
			if (req.clr) begin
				row_any_q <= '0;
			end else if (req.wr_en) begin
				row_any_q[req.wr_row] <= |req.wr_data;
			end
			if (req.rd_en) begin
				rd_any_q <= row_any_q[req.rd_row];
			end
		end
	end

	assign rsp.rd_data = rd_any_q ? rd_data_q : '0;
	assign rsp.row_any = row_any_q;

endmodule

// ----- src/mva_checker.sv -----
// Port-level checks for the MIDI voice allocator, bound to the top level.
`include "midi_voice_allocator_assert.svh"

module mva_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [2:0]  m_tuser
);

	mva_pkg::out_word_t ow;
	logic               is_start, is_plain_release;

	assign ow = m_tdata;
	assign is_start = m_tvalid && (m_tuser == mva_pkg::ACT_START);
	assign is_plain_release = m_tvalid && ((m_tuser == mva_pkg::ACT_RELEASE) ||
		(m_tuser == mva_pkg::ACT_RELEASE_ALL) || (m_tuser == mva_pkg::ACT_NO_VOICE));

	// One message in flight: the block never takes two words on consecutive edges.
	`MVA_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "word accepted twice in a row")

	// A started note frees nothing and carries a real velocity.
	`MVA_ASSERT_IMP(a_start_fields, clk, arst_n, is_start, ow.released_mask == 8'd0 && ow.velocity != 7'd0, "bad start word")

	// Releases and refusals carry no voice, note or velocity.
	`MVA_ASSERT_IMP(a_release_zero, clk, arst_n, is_plain_release, ow.voice == 3'd0 && ow.note_number == 7'd0 && ow.velocity == 7'd0, "release word has voice fields")

	// A stalled result word holds.
	`MVA_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

endmodule

bind midi_voice_allocator mva_checker u_mva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
